FILE: design/chaoslfo_pkg.sv
// Shared types, constants and helpers for the chaos-modulated sine LFO.
package chaoslfo_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF = 32;

  localparam int REG_ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_BASE_INC  = 3'd0,
    REG_CHAOS_INC = 3'd1,
    REG_MIN_INC   = 3'd2,
    REG_AMOUNT    = 3'd3,
    REG_OFFSET    = 3'd4,
    REG_GATE_THR  = 3'd5
  } reg_idx_t;

  localparam logic [31:0] BASE_INC_RST  = 32'd89478;
  localparam logic [31:0] CHAOS_INC_RST = 32'd44739;
  localparam logic [31:0] MIN_INC_RST   = 32'd895;
  localparam logic [16:0] AMOUNT_RST    = 17'd0;
  localparam logic [15:0] OFFSET_RST    = 16'd0;
  localparam logic signed [15:0] GATE_THR_RST = 16'sd3277;

  localparam logic [16:0] AMOUNT_FULL = 17'd65536;
  localparam logic [14:0] SINE_MAX    = 15'd32767;

  localparam logic [31:0] Q30_C1 = 32'd1686629713;
  localparam logic [31:0] Q30_C3 = 32'd693598668;
  localparam logic [31:0] Q30_C5 = 32'd85569306;
  localparam logic [31:0] Q30_C7 = 32'd5026995;
  localparam logic [31:0] Q30_C9 = 32'd172272;

  localparam logic signed [33:0] MULT_ONE = 34'sd536870912;

  typedef struct packed {
    logic              gate_connected;
    logic signed [15:0] gate_sample;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] sine_value;
    logic               gate_high;
  } lfo_t;

  typedef struct packed {
    logic [31:0]        base_increment;
    logic [31:0]        chaos_increment;
    logic [31:0]        min_increment;
    logic [16:0]        chaos_amount;
    logic [15:0]        phase_offset;
    logic signed [15:0] gate_threshold;
  } cfg_t;

  // Scale a Q30 sine magnitude to Q1.15 with rounding and saturation.
  function automatic logic [14:0] round_sine(input logic [32:0] s);
    logic [47:0] t;
    logic [17:0] v;
    t = ({15'd0, s} << 15) - {15'd0, s} + 48'h0000_2000_0000;
    v = t[47:30];
    if (v > {3'd0, SINE_MAX}) begin
      return SINE_MAX;
    end
    return v[14:0];
  endfunction

endpackage

FILE: design/chaos_modulated_sine_lfo_core.sv
// Top level of the chaos-modulated sine LFO: sequencer around one shared multiplier.
//
// Each accepted sample word advances a slow chaos phase, takes its sine at the
// configured offset, scales the base step by 1 + 3 * amount * sine, clamps it,
// advances the main phase and returns one word with the main-phase sine and a
// gate flag. Both sines are computed with a ninth-order quarter-wave polynomial
// evaluated on a single 32x32 multiplier, each product passing through S_MUL and
// S_USE. The scaling product is skipped when the modulated step falls to zero or
// below. sample_ready is high only while the sequencer is idle, so the next word
// is accepted only after the result word has been issued. A finished result waits
// in its output register without blocking the next word, up to the point where
// a second result would overwrite it.
module chaos_modulated_sine_lfo_core
  import chaoslfo_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  sample_t                  sample,
  output logic                     lfo_valid,
  input  logic                     lfo_ready,
  output lfo_t                     lfo,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int XSHIFT = 30 - QBITS;

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_MUL, S_USE} state_t;
  typedef enum logic [2:0] {
    SEQ_SQ, SEQ_C7, SEQ_C5, SEQ_C3, SEQ_C1, SEQ_SIN, SEQ_MOD, SEQ_SCALE
  } seq_t;

  cfg_t   cfg;
  state_t state;
  seq_t   seq;

  logic [PHASE_BITS-1:0] main_phase;
  logic [PHASE_BITS-1:0] chaos_phase;
  logic                  pass_main;
  logic [16:0]           amt;
  logic [1:0]            quad;
  logic [30:0]           x_arg;
  logic [30:0]           x2;
  logic                  chaos_neg;
  logic [31:0]           op_a;
  logic [31:0]           op_b;
  logic [63:0]           prod;

  logic [16:0]             amt_next;
  logic [PHASE_BITS-1:0]   phase_sel;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [QBITS-1:0]        r;
  logic [QBITS:0]          m;
  logic [30:0]             x_next;
  logic [31:0]             coef;
  logic [31:0]             poly_next;
  logic [14:0]             v_now;
  logic [17:0]             amt3;
  logic [31:0]             mag;
  logic signed [33:0]      mult_s;
  logic [31:0]             scaled;
  logic [31:0]             step_val;
  logic                    emit;

  chaoslfo_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready       = 1'b1;
  assign sample_ready = (state == S_IDLE);

  always_comb begin
    if (sample.gate_connected && (sample.gate_sample < cfg.gate_threshold)) begin
      amt_next = 17'd0;
    end else if (cfg.chaos_amount > AMOUNT_FULL) begin
      amt_next = AMOUNT_FULL;
    end else begin
      amt_next = cfg.chaos_amount;
    end
  end

  assign phase_sel = pass_main ? main_phase
                   : chaos_phase + (PHASE_BITS'(cfg.phase_offset) << (PHASE_BITS - 16));
  assign k      = phase_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign r      = k[QBITS-1:0];
  assign m      = k[QBITS] ? ((QBITS+1)'(1) << QBITS) - {1'b0, r} : {1'b0, r};
  assign x_next = 31'(m) << XSHIFT;

  always_comb begin
    case (seq)
      SEQ_C7:  coef = Q30_C7;
      SEQ_C5:  coef = Q30_C5;
      SEQ_C3:  coef = Q30_C3;
      SEQ_C1:  coef = Q30_C1;
      default: coef = 32'd0;
    endcase
  end

  assign poly_next = coef - prod[61:30];
  assign v_now     = round_sine(prod[62:30]);
  assign amt3      = {amt, 1'b0} + {1'b0, amt};
  assign mag       = prod[33:2];
  assign mult_s    = chaos_neg ? MULT_ONE - $signed({2'b00, mag})
                               : MULT_ONE + $signed({2'b00, mag});
  assign scaled    = (prod[63:61] != 3'd0) ? 32'hFFFF_FFFF : prod[60:29];
  assign step_val  = (scaled < cfg.min_increment) ? cfg.min_increment : scaled;
  assign emit      = (state == S_USE) && (seq == SEQ_SIN) && pass_main
                   && (!lfo_valid || lfo_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seq         <= SEQ_SQ;
      lfo_valid   <= 1'b0;
      pass_main   <= 1'b0;
      main_phase  <= '0;
      chaos_phase <= '0;
    end else begin
      if (emit) begin
        lfo_valid <= 1'b1;
      end else if (lfo_valid && lfo_ready) begin
        lfo_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            chaos_phase <= chaos_phase + PHASE_BITS'(cfg.chaos_increment);
            amt         <= amt_next;
            pass_main   <= 1'b0;
            state       <= S_SETUP;
          end
        end
        S_SETUP: begin
          quad  <= k[SINE_TABLE_BITS-1 -: 2];
          x_arg <= x_next;
          op_a  <= {1'b0, x_next};
          op_b  <= {1'b0, x_next};
          seq   <= SEQ_SQ;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= op_a * op_b;
          state <= S_USE;
        end
        S_USE: begin
          case (seq)
            SEQ_SQ: begin
              x2    <= prod[60:30];
              op_a  <= Q30_C9;
              op_b  <= {1'b0, prod[60:30]};
              seq   <= SEQ_C7;
              state <= S_MUL;
            end
            SEQ_C7, SEQ_C5, SEQ_C3: begin
              op_a  <= poly_next;
              op_b  <= {1'b0, x2};
              seq   <= (seq == SEQ_C7) ? SEQ_C5 : (seq == SEQ_C5) ? SEQ_C3 : SEQ_C1;
              state <= S_MUL;
            end
            SEQ_C1: begin
              op_a  <= poly_next;
              op_b  <= {1'b0, x_arg};
              seq   <= SEQ_SIN;
              state <= S_MUL;
            end
            SEQ_SIN: begin
              if (!pass_main) begin
                op_a      <= 32'(amt3);
                op_b      <= 32'(v_now);
                chaos_neg <= quad[1];
                seq       <= SEQ_MOD;
                state     <= S_MUL;
              end else if (emit) begin
                lfo.sine_value <= quad[1] ? -$signed({1'b0, v_now})
                                          : $signed({1'b0, v_now});
                lfo.gate_high  <= !(quad[1] && (v_now != 15'd0));
                state          <= S_IDLE;
              end
            end
            SEQ_MOD: begin
              if (mult_s <= 34'sd0) begin
                main_phase <= main_phase + PHASE_BITS'(cfg.min_increment);
                pass_main  <= 1'b1;
                state      <= S_SETUP;
              end else begin
                op_a  <= cfg.base_increment;
                op_b  <= mult_s[31:0];
                seq   <= SEQ_SCALE;
                state <= S_MUL;
              end
            end
            SEQ_SCALE: begin
              main_phase <= main_phase + PHASE_BITS'(step_val);
              pass_main  <= 1'b1;
              state      <= S_SETUP;
            end
            default: state <= S_IDLE;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/chaoslfo_regs.sv
// Configuration register file behind the APB-style port.
module chaoslfo_regs
  import chaoslfo_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output cfg_t                     cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[REG_ADDR_BITS-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_increment  <= BASE_INC_RST;
      cfg.chaos_increment <= CHAOS_INC_RST;
      cfg.min_increment   <= MIN_INC_RST;
      cfg.chaos_amount    <= AMOUNT_RST;
      cfg.phase_offset    <= OFFSET_RST;
      cfg.gate_threshold  <= GATE_THR_RST;
    end else if (wr) begin
      case (idx)
        REG_BASE_INC:  cfg.base_increment  <= pwdata;
        REG_CHAOS_INC: cfg.chaos_increment <= pwdata;
        REG_MIN_INC:   cfg.min_increment   <= pwdata;
        REG_AMOUNT:    cfg.chaos_amount    <= pwdata[16:0];
        REG_OFFSET:    cfg.phase_offset    <= pwdata[15:0];
        REG_GATE_THR:  cfg.gate_threshold  <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE_INC:  prdata = cfg.base_increment;
      REG_CHAOS_INC: prdata = cfg.chaos_increment;
      REG_MIN_INC:   prdata = cfg.min_increment;
      REG_AMOUNT:    prdata = {15'd0, cfg.chaos_amount};
      REG_OFFSET:    prdata = {16'd0, cfg.phase_offset};
      REG_GATE_THR:  prdata = {{16{cfg.gate_threshold[15]}}, cfg.gate_threshold};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

FILE: tb/testbench.sv
// Testbench for chaos_modulated_sine_lfo_core: directed table and random words against a predictor.
module testbench;
  import chaoslfo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TBL_BITS = SINE_TABLE_BITS_DEF;
  localparam int ACC_BITS = PHASE_BITS_DEF;
  localparam int RAND_BLOCKS = 7;
  localparam int BLOCK_WORDS = 148;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic        wr;
    logic [2:0]  idx;
    logic [31:0] data;
    sample_t     word;
    logic        typed;
    lfo_t        want;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     sample_valid;
  logic                     sample_ready;
  sample_t                  sample;
  logic                     lfo_valid;
  logic                     lfo_ready;
  lfo_t                     lfo;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [REG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  cfg_t        lfo_cfg;
  logic [31:0] main_acc;
  logic [31:0] chaos_acc;
  lfo_t        lfo_due[$];
  stim_row_t   plan[$];
  int          errors;
  int          cycles;
  logic        burst_in;
  logic        burst_out;

  chaos_modulated_sine_lfo_core u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .lfo_valid    (lfo_valid),
    .lfo_ready    (lfo_ready),
    .lfo          (lfo),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("chaos_modulated_sine_lfo_core: mismatch");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic signed [15:0] sine_lookup(input int unsigned k);
    int unsigned quarter;
    int unsigned q;
    int unsigned r;
    int unsigned m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    quarter = 1 << (TBL_BITS - 2);
    k = k & ((1 << TBL_BITS) - 1);
    q = k >> (TBL_BITS - 2);
    r = k & (quarter - 1);
    m = q[0] ? quarter - r : r;
    x = (64'(m) << 30) >> (TBL_BITS - 2);
    x2 = (x * x) >> 30;
    p = 64'(Q30_C9);
    p = 64'(Q30_C7) - ((p * x2) >> 30);
    p = 64'(Q30_C5) - ((p * x2) >> 30);
    p = 64'(Q30_C3) - ((p * x2) >> 30);
    p = 64'(Q30_C1) - ((p * x2) >> 30);
    s = (p * x) >> 30;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return q[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
  endfunction

  function automatic logic signed [15:0] phase_sine(input logic [31:0] ph);
    return sine_lookup(ph >> (ACC_BITS - TBL_BITS));
  endfunction

  function automatic lfo_t next_lfo(input sample_t w);
    logic signed [63:0] amt;
    logic signed [63:0] csine;
    logic signed [63:0] term;
    logic signed [63:0] mult;
    logic [63:0]        step;
    logic signed [15:0] sv;
    lfo_t               res;
    amt = (lfo_cfg.chaos_amount > AMOUNT_FULL) ? 64'sd65536 : $signed({47'd0, lfo_cfg.chaos_amount});
    if (w.gate_connected && w.gate_sample < lfo_cfg.gate_threshold) begin
      amt = 0;
    end
    chaos_acc = chaos_acc + lfo_cfg.chaos_increment;
    csine = phase_sine(chaos_acc + {lfo_cfg.phase_offset, 16'd0});
    term = 64'sd3 * amt * csine;
    mult = 64'sd536870912 + term / 64'sd4;
    if (mult <= 0) begin
      step = {32'd0, lfo_cfg.min_increment};
    end else begin
      step = ({32'd0, lfo_cfg.base_increment} * mult[63:0]) >> 29;
      if (step > 64'hFFFF_FFFF) begin
        step = 64'hFFFF_FFFF;
      end
      if (step < {32'd0, lfo_cfg.min_increment}) begin
        step = {32'd0, lfo_cfg.min_increment};
      end
    end
    main_acc = main_acc + step[31:0];
    sv = phase_sine(main_acc);
    res.sine_value = sv;
    res.gate_high = ~sv[15];
    return res;
  endfunction

  task automatic add_item(input logic gc, input logic [15:0] gs);
    stim_row_t row;
    row = '{wr: 1'b0, idx: '0, data: '0, word: '{gc, gs}, typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  task automatic add_typed(input logic gc, input logic [15:0] gs, input logic [15:0] sv,
                           input logic gh);
    stim_row_t row;
    row = '{wr: 1'b0, idx: '0, data: '0, word: '{gc, gs}, typed: 1'b1, want: '{sv, gh}};
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [31:0] val);
    stim_row_t row;
    row = '{wr: 1'b1, idx: idx, data: val, word: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  task automatic send_word(input sample_t w, input logic typed, input lfo_t want);
    int   gap;
    lfo_t calc;
    if ($urandom_range(0, 19) == 0) begin
      burst_in = ~burst_in;
    end
    gap = burst_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample <= w;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    calc = next_lfo(w);
    lfo_due.push_back(typed ? want : calc);
  endtask

  // drop valid, wait for every pending result, then let the core go idle
  task automatic settle();
    sample_valid <= 1'b0;
    while (lfo_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE_INC:  lfo_cfg.base_increment = val;
      REG_CHAOS_INC: lfo_cfg.chaos_increment = val;
      REG_MIN_INC:   lfo_cfg.min_increment = val;
      REG_AMOUNT:    lfo_cfg.chaos_amount = val[16:0];
      REG_OFFSET:    lfo_cfg.phase_offset = val[15:0];
      REG_GATE_THR:  lfo_cfg.gate_threshold = val[15:0];
      default: ;
    endcase
  endtask

  task automatic reg_read(input logic [2:0] idx);
    logic [31:0] want;
    logic [31:0] mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE_INC:  begin want = lfo_cfg.base_increment; mask = '1; end
      REG_CHAOS_INC: begin want = lfo_cfg.chaos_increment; mask = '1; end
      REG_MIN_INC:   begin want = lfo_cfg.min_increment; mask = '1; end
      REG_AMOUNT:    begin want = {15'd0, lfo_cfg.chaos_amount}; mask = 32'h1_FFFF; end
      REG_OFFSET:    begin want = {16'd0, lfo_cfg.phase_offset}; mask = 32'hFFFF; end
      default:       begin want = {16'd0, lfo_cfg.gate_threshold}; mask = 32'hFFFF; end
    endcase
    if ((prdata & mask) !== want) begin
      report($sformatf("register %0d reads 0x%08h, want 0x%08h", idx, prdata & mask, want));
    end
  endtask

  // read back every register and release the port
  task automatic close_cfg();
    for (int i = REG_BASE_INC; i <= REG_GATE_THR; i++) begin
      reg_read(3'(i));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_wide();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] amt;
    logic [31:0] thr;
    logic [31:0] lo;
    case ($urandom_range(0, 4))
      0: amt = 32'd0;
      1: amt = {15'd0, AMOUNT_FULL};
      2: amt = 32'h1_FFFF;
      3: amt = $urandom;
      default: amt = $urandom_range(0, 65536);
    endcase
    case ($urandom_range(0, 3))
      0: thr = 32'h8000;
      1: thr = 32'h7FFF;
      2: thr = $urandom_range(0, 8000);
      default: thr = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: lo = 32'hFFFF_FFFF;
      1: lo = $urandom;
      2: lo = 32'd0;
      default: lo = $urandom_range(0, 1 << 16);
    endcase
    reg_write(REG_BASE_INC, pick_wide());
    reg_write(REG_CHAOS_INC, pick_wide());
    reg_write(REG_MIN_INC, lo);
    reg_write(REG_AMOUNT, amt);
    reg_write(REG_OFFSET, $urandom);
    reg_write(REG_GATE_THR, thr);
    if ($urandom_range(0, 2) == 0) begin
      reg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    end
    close_cfg();
  endtask

  initial begin
    lfo_t    want;
    while (1) begin
      while (rst !== 1'b0) @(posedge clk);
      if ($urandom_range(0, 19) == 0) begin
        burst_out = ~burst_out;
      end
      if (!burst_out) begin
        int stall;
        stall = $urandom_range(0, 6);
        if (stall > 0) begin
          lfo_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      lfo_ready <= 1'b1;
      do @(posedge clk); while (!lfo_valid);
      if (lfo_due.size() == 0) begin
        report("result word with nothing pending");
      end else begin
        want = lfo_due.pop_front();
        if (lfo.sine_value !== want.sine_value) begin
          report($sformatf("sine_value %0d, want %0d", lfo.sine_value, want.sine_value));
        end
        if (lfo.gate_high !== want.gate_high) begin
          report($sformatf("gate_high %0b, want %0b", lfo.gate_high, want.gate_high));
        end
      end
    end
  end

  initial begin
    logic    cfg_open;
    sample_t w;
    logic [15:0] thr;
    clk = 1'b0;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    lfo_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    burst_in = 1'b0;
    burst_out = 1'b0;
    cfg_open = 1'b0;
    lfo_cfg = '{BASE_INC_RST, CHAOS_INC_RST, MIN_INC_RST, AMOUNT_RST, OFFSET_RST, GATE_THR_RST};
    main_acc = '0;
    chaos_acc = '0;

    // reset settings, zero depth: main phase stays in the first table entry
    add_typed(1'b0, 16'h8000, 16'sd0, 1'b1);
    add_typed(1'b1, 16'h8000, 16'sd0, 1'b1);
    add_typed(1'b1, 16'sd3276, 16'sd0, 1'b1);
    add_typed(1'b1, 16'sd3277, 16'sd0, 1'b1);
    add_typed(1'b0, 16'h7FFF, 16'sd0, 1'b1);
    add_typed(1'b1, 16'h7FFF, 16'sd0, 1'b1);
    // depth above full, chaos sine near peak: step saturates at the top
    add_cfg(REG_BASE_INC, 32'hFFFF_FFFF);
    add_cfg(REG_CHAOS_INC, 32'd0);
    add_cfg(REG_AMOUNT, 32'h1_FFFF);
    add_cfg(REG_OFFSET, 32'h4000);
    add_cfg(REG_GATE_THR, 32'h8000);
    add_item(1'b0, 16'h0000);
    add_item(1'b1, 16'h8000);
    add_item(1'b1, 16'h7FFF);
    // chaos sine near trough: multiplier goes negative unless the gate is low
    add_cfg(REG_OFFSET, 32'hC000);
    add_cfg(REG_MIN_INC, 32'h1234_5678);
    add_cfg(REG_GATE_THR, 32'h7FFF);
    add_item(1'b1, 16'h8000);
    add_item(1'b1, 16'h7FFF);
    add_item(1'b0, 16'h8000);
    add_item(1'b0, 16'h0000);
    // zero base step raised to the minimum
    add_cfg(REG_BASE_INC, 32'd0);
    add_cfg(REG_MIN_INC, 32'hFFFF_FFFF);
    add_cfg(REG_AMOUNT, {15'd0, AMOUNT_FULL});
    add_cfg(REG_OFFSET, 32'd0);
    add_cfg(REG_CHAOS_INC, 32'hFFFF_FFFF);
    add_item(1'b0, 16'h0000);
    add_item(1'b1, 16'h0001);
    add_item(1'b0, 16'hFFFF);
    // spare addresses ignored, wide values masked to register width
    add_cfg(REG_SPARE_LO, 32'hFFFF_FFFF);
    add_cfg(REG_SPARE_HI, 32'd0);
    add_cfg(REG_AMOUNT, 32'hFFFF_FFFF);
    add_cfg(REG_OFFSET, 32'hFFFF_FFFF);
    add_cfg(REG_GATE_THR, 32'hFFFF_FFFF);
    add_cfg(REG_BASE_INC, 32'h8000_0000);
    add_cfg(REG_MIN_INC, 32'd0);
    add_item(1'b1, 16'hFFFE);
    add_item(1'b1, 16'hFFFF);
    add_item(1'b0, 16'sd12345);
    add_item(1'b1, 16'h0000);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        reg_write(plan[i].idx, plan[i].data);
      end else begin
        if (cfg_open) begin
          close_cfg();
          cfg_open = 1'b0;
        end
        send_word(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    for (int b = 0; b < RAND_BLOCKS; b++) begin
      settle();
      random_setup();
      thr = lfo_cfg.gate_threshold;
      for (int n = 0; n < BLOCK_WORDS; n++) begin
        w.gate_connected = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0: w.gate_sample = 16'h8000;
          1: w.gate_sample = 16'h7FFF;
          2: w.gate_sample = thr - 16'd1;
          3: w.gate_sample = thr;
          default: w.gate_sample = 16'($urandom);
        endcase
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0 && lfo_due.size() == 0) begin
      $display("chaos_modulated_sine_lfo_core: match");
    end else begin
      $display("chaos_modulated_sine_lfo_core: mismatch");
    end
    $finish;
  end

endmodule
